[hdl/mtpp_pkg.sv]
// Package for the median-threshold peak picker.
// Item and register types, register indexes and reset values.
// No dependencies.
package mtpp_pkg;

  localparam int HALF_MAX_DEF   = 32;
  localparam int INDEX_BITS_DEF = 20;

  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 20;
  localparam int HALF_W   = 6;
  localparam int GAP_W    = 8;
  localparam int SCALE_W  = 11;
  localparam int FLOOR_W  = 16;
  localparam int CFG_W    = 16;

  localparam logic [HALF_W-1:0]  HALF_RST  = 6'd28;
  localparam logic [GAP_W-1:0]   GAP_RST   = 8'd9;
  localparam logic [SCALE_W-1:0] SCALE_RST = 11'd410;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 16'd1311;

  typedef enum logic [1:0] {
    CFG_HALF_WINDOW     = 2'd0,
    CFG_REFRACTORY_GAP  = 2'd1,
    CFG_MEDIAN_SCALE    = 2'd2,
    CFG_THRESHOLD_FLOOR = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] envelope_sample;
    logic                final_sample;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  onset_frame;
    logic [SAMPLE_W-1:0] onset_strength;
    logic                end_marker;
    logic                run_last;
  } out_item_t;

  // Effective register values as the datapath uses them
  typedef struct packed {
    logic [GAP_W-1:0]   refractory_gap;
    logic [SCALE_W-1:0] median_scale;
    logic [FLOOR_W-1:0] threshold_floor;
  } cfg_eff_t;

endpackage

[hdl/mtpp_cfg.sv]
// Configuration registers of the peak picker, with range clamping.
// Depends on mtpp_pkg.
module mtpp_cfg #(
  parameter int HALF_MAX = mtpp_pkg::HALF_MAX_DEF,
  parameter int PTR_W    = $clog2(2 * HALF_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  mtpp_pkg::cfg_idx_t  cfg_index,
  input  logic [mtpp_pkg::CFG_W-1:0] cfg_data,
  output logic                cfg_ready,
  output mtpp_pkg::cfg_eff_t  eff,
  output logic [PTR_W-1:0]    half_eff
);
  import mtpp_pkg::*;

  logic [HALF_W-1:0]  half_r;
  logic [GAP_W-1:0]   gap_r;
  logic [SCALE_W-1:0] scale_r;
  logic [FLOOR_W-1:0] floor_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_RST;
      gap_r   <= GAP_RST;
      scale_r <= SCALE_RST;
      floor_r <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_WINDOW:     half_r  <= cfg_data[HALF_W-1:0];
        CFG_REFRACTORY_GAP:  gap_r   <= cfg_data[GAP_W-1:0];
        CFG_MEDIAN_SCALE:    scale_r <= cfg_data[SCALE_W-1:0];
        CFG_THRESHOLD_FLOOR: floor_r <= cfg_data[FLOOR_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (half_r == '0) begin
      half_eff = PTR_W'(1);
    end else if (int'(half_r) > HALF_MAX) begin
      half_eff = PTR_W'(HALF_MAX);
    end else begin
      half_eff = PTR_W'(half_r);
    end
    eff.refractory_gap  = (gap_r == '0) ? GAP_W'(1) : gap_r;
    eff.median_scale    = scale_r;
    eff.threshold_floor = floor_r;
  end

endmodule

[hdl/mtpp_ring.sv]
// Sample ring memory: one write port, one read port with registered data.
// Depends on mtpp_pkg.
module mtpp_ring #(
  parameter int DEPTH  = 2 * mtpp_pkg::HALF_MAX_DEF + 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [mtpp_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [mtpp_pkg::SAMPLE_W-1:0] rd_data_r
);
  import mtpp_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[hdl/mtpp_out_reg.sv]
// Output register holding one result item under the valid/stall handshake.
// Depends on mtpp_pkg.
module mtpp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mtpp_pkg::out_item_t load_item,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_stall,
  output mtpp_pkg::out_item_t out_data
);
  import mtpp_pkg::*;

  logic valid_r;

  assign out_valid = valid_r;
  assign slot_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_item;
    end
  end

endmodule

[hdl/median_threshold_peak_picker.sv]
// Onset peak picker with an adaptive median threshold. Each envelope item is
// written to a sample ring and the frame half_window back is judged. A frame that
// fails the neighbor or refractory test skips the median search; one that passes
// also needs the window's upper median, found by a 16-step bitwise rank search
// that streams the whole window through one compare unit and the ring's single
// read port, for a window of up to 2*HALF_MAX+1 frames.
// A final item judges every pending frame in order, then sends an end marker and
// clears the frame count, onset history and ring fill. in_stall is high from
// acceptance until the FSM is back in idle, after the item's results are all
// loaded into the output register.
module median_threshold_peak_picker #(
  parameter int HALF_MAX   = mtpp_pkg::HALF_MAX_DEF,
  parameter int INDEX_BITS = mtpp_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mtpp_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mtpp_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  mtpp_pkg::cfg_idx_t         cfg_index,
  input  logic [mtpp_pkg::CFG_W-1:0] cfg_data
);
  import mtpp_pkg::*;

  localparam int RING_DEPTH = 2 * HALF_MAX + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int AW         = PTR_W + 1;
  localparam int BIT_W      = $clog2(SAMPLE_W);
  localparam int PROD_W     = SAMPLE_W + SCALE_W;
  localparam int SUM_W      = PROD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RDL, S_RDR, S_TEST, S_MRUN, S_MLAST,
    S_MUL, S_CMP, S_EMIT, S_NEXT, S_END
  } state_t;

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      b_r, b_nxt;
  logic                  fin_r, fin_nxt;
  logic [INDEX_BITS-1:0] newest_r, newest_nxt;
  logic [INDEX_BITS-1:0] fc_r, fc_nxt;
  logic [INDEX_BITS-1:0] prev_r, prev_nxt;
  logic                  seen_r, seen_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [SAMPLE_W-1:0]   v_r, v_nxt;
  logic [PTR_W-1:0]      hi_r, hi_nxt;
  logic [PTR_W-1:0]      idx_r, idx_nxt;
  logic [PTR_W-1:0]      rank_r, rank_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [SAMPLE_W-1:0]   prefix_r, prefix_nxt;
  logic                  pend_r, pend_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;

  cfg_eff_t              eff;
  logic [PTR_W-1:0]      half_eff;
  logic                  in_acc;
  logic [PTR_W-1:0]      rd_idx;
  logic [AW-1:0]         pos_sum;
  logic [PTR_W-1:0]      rd_addr;
  logic [SAMPLE_W-1:0]   rd_data;
  logic [SAMPLE_W-1:0]   cand;
  logic                  lt;
  logic [CNT_W-1:0]      cnt_fin;
  logic [INDEX_BITS-1:0] t_idx;
  logic [INDEX_BITS-1:0] gap_dist;
  logic [AW-1:0]         below_full;
  logic [AW-1:0]         below;
  logic [AW-1:0]         hi_full;
  logic [SUM_W-1:0]      rhs;
  logic [SUM_W-1:0]      lhs;
  logic [FRAME_W+INDEX_BITS-1:0] frame_ext;
  logic                  slot_free;
  logic                  load;
  out_item_t             load_item;

  mtpp_cfg #(.HALF_MAX(HALF_MAX), .PTR_W(PTR_W)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .eff       (eff),
    .half_eff  (half_eff)
  );

  mtpp_ring #(.DEPTH(RING_DEPTH), .ADDR_W(PTR_W)) u_ring (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_addr   (wp_r),
    .wr_data   (in_data.envelope_sample),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  mtpp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_item (load_item),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Ring address of the sample rd_idx positions back from the newest one
  always_comb begin
    case (state_r)
      S_RDL:   rd_idx = PTR_W'(AW'(b_r) + AW'(1));
      S_RDR:   rd_idx = b_r - PTR_W'(1);
      S_MRUN:  rd_idx = idx_r;
      default: rd_idx = b_r;
    endcase
    pos_sum = AW'(wp_r) + AW'(RING_DEPTH - 1) - AW'(rd_idx);
    if (pos_sum >= AW'(RING_DEPTH)) begin
      rd_addr = PTR_W'(pos_sum - AW'(RING_DEPTH));
    end else begin
      rd_addr = PTR_W'(pos_sum);
    end
  end

  always_comb begin
    cand       = prefix_r | (SAMPLE_W'(1) << bit_r);
    lt         = rd_data < cand;
    cnt_fin    = cnt_r + CNT_W'(lt);
    t_idx      = newest_r - INDEX_BITS'(b_r);
    gap_dist   = t_idx - prev_r;
    below_full = AW'(fill_r) - AW'(1) - AW'(b_r);
    below      = (below_full > AW'(half_eff)) ? AW'(half_eff) : below_full;
    hi_full    = AW'(b_r) + below;
    lhs        = SUM_W'({v_r, 8'd0});
    rhs        = SUM_W'(prod_r) + SUM_W'({eff.threshold_floor, 8'd0});
    frame_ext  = {{FRAME_W{1'b0}}, t_idx};
  end

  always_comb begin
    state_nxt  = state_r;
    b_nxt      = b_r;
    fin_nxt    = fin_r;
    newest_nxt = newest_r;
    fc_nxt     = fc_r;
    prev_nxt   = prev_r;
    seen_nxt   = seen_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    v_nxt      = v_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    rank_nxt   = rank_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    prefix_nxt = prefix_r;
    pend_nxt   = pend_r;
    prod_nxt   = prod_r;
    load       = 1'b0;
    load_item  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wp_nxt     = (wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
          fill_nxt   = (fill_r == CNT_W'(RING_DEPTH)) ? fill_r : fill_r + CNT_W'(1);
          newest_nxt = fc_r;
          fc_nxt     = fc_r + INDEX_BITS'(1);
          fin_nxt    = in_data.final_sample;
          b_nxt      = half_eff;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        // Needs both neighbors in the ring; issues the read of the frame itself
        if (AW'(fill_r) < AW'(b_r) + AW'(2)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        v_nxt     = rd_data;
        state_nxt = S_RDR;
      end
      S_RDR: begin
        state_nxt = (v_r < rd_data) ? S_NEXT : S_TEST;
      end
      S_TEST: begin
        if (v_r < rd_data) begin
          state_nxt = S_NEXT;
        end else if (seen_r && (gap_dist < INDEX_BITS'(eff.refractory_gap))) begin
          state_nxt = S_NEXT;
        end else begin
          hi_nxt     = PTR_W'(hi_full);
          rank_nxt   = PTR_W'((hi_full + AW'(1)) >> 1);
          idx_nxt    = '0;
          cnt_nxt    = '0;
          pend_nxt   = 1'b0;
          bit_nxt    = BIT_W'(SAMPLE_W - 1);
          prefix_nxt = '0;
          state_nxt  = S_MRUN;
        end
      end
      S_MRUN: begin
        // Count window entries below the trial value, one per cycle
        if (pend_r) begin
          cnt_nxt = cnt_fin;
        end
        pend_nxt = 1'b1;
        if (idx_r == hi_r) begin
          state_nxt = S_MLAST;
        end else begin
          idx_nxt = idx_r + PTR_W'(1);
        end
      end
      S_MLAST: begin
        if (AW'(cnt_fin) <= AW'(rank_r)) begin
          prefix_nxt = cand;
        end
        if (bit_r == '0) begin
          state_nxt = S_MUL;
        end else begin
          bit_nxt   = bit_r - BIT_W'(1);
          idx_nxt   = '0;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_MRUN;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(prefix_r) * PROD_W'(eff.median_scale);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = (lhs >= rhs) ? S_EMIT : S_NEXT;
      end
      S_EMIT: begin
        if (slot_free) begin
          load                     = 1'b1;
          load_item.onset_frame    = frame_ext[FRAME_W-1:0];
          load_item.onset_strength = v_r;
          load_item.end_marker     = 1'b0;
          load_item.run_last       = !fin_r;
          prev_nxt                 = t_idx;
          seen_nxt                 = 1'b1;
          state_nxt                = S_NEXT;
        end
      end
      S_NEXT: begin
        if (fin_r && (b_r > PTR_W'(1))) begin
          b_nxt     = b_r - PTR_W'(1);
          state_nxt = S_CHECK;
        end else if (fin_r) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_END: begin
        if (slot_free) begin
          load                 = 1'b1;
          load_item.end_marker = 1'b1;
          load_item.run_last   = 1'b1;
          fc_nxt               = '0;
          prev_nxt             = '0;
          seen_nxt             = 1'b0;
          wp_nxt               = '0;
          fill_nxt             = '0;
          state_nxt            = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fc_r    <= '0;
      prev_r  <= '0;
      seen_r  <= 1'b0;
      wp_r    <= '0;
      fill_r  <= '0;
      fin_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      prev_r  <= prev_nxt;
      seen_r  <= seen_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      fin_r   <= fin_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r      <= b_nxt;
    newest_r <= newest_nxt;
    v_r      <= v_nxt;
    hi_r     <= hi_nxt;
    idx_r    <= idx_nxt;
    rank_r   <= rank_nxt;
    cnt_r    <= cnt_nxt;
    bit_r    <= bit_nxt;
    prefix_r <= prefix_nxt;
    prod_r   <= prod_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(RING_DEPTH))
    else $error("ring fill beyond depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < PTR_W'(RING_DEPTH))
    else $error("ring write pointer out of range");

  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_marker) |->
      (out_data.run_last && out_data.onset_frame == '0 && out_data.onset_strength == '0))
    else $error("malformed end marker item");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && slot_free) |=> (fill_r == '0 && fc_r == '0 && !seen_r))
    else $error("state not cleared after final item");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRUN) |-> (idx_r <= hi_r && AW'(hi_r) < AW'(fill_r)))
    else $error("median scan outside valid window");

endmodule
